// File: rtl/tlfs_pkg.sv
package tlfs_pkg;

    // Sequencer phases: the four steady phases, then the transitions
    typedef enum logic [3:0] {
        PH_STOP        = 4'd0,
        PH_GO          = 4'd1,
        PH_WARN        = 4'd2,
        PH_XWALK       = 4'd3,
        PH_STOP_GO     = 4'd4,
        PH_STOP_GO_T   = 4'd5,
        PH_STOP_WARN   = 4'd6,
        PH_GO_WARN     = 4'd7,
        PH_WARN_STOP   = 4'd8,
        PH_WARN_STOP_T = 4'd9,
        PH_XWALK_GO    = 4'd10,
        PH_WARN_XWALK  = 4'd11
    } phase_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_TOUCH_THRESHOLD = 2'd0,
        REG_MAIN_DWELL      = 2'd1,
        REG_WARN_DWELL      = 2'd2
    } reg_idx_t;

    localparam logic [15:0] TOUCH_THRESHOLD_RST = 16'd160;
    localparam logic [11:0] MAIN_DWELL_RST      = 12'd320;
    localparam logic [11:0] WARN_DWELL_RST      = 12'd80;

    localparam logic [11:0] TIMER_MAX     = 12'd4095;
    localparam logic [11:0] BLINK_OFF_END = 12'd4;
    localparam logic [11:0] BLINK_ON_END  = 12'd16;
    localparam logic [2:0]  BLINK_TOTAL   = 3'd5;
    localparam logic [15:0] XWALK_GREEN   = 16'd3000;
    localparam logic [15:0] XWALK_BLUE    = 16'd9000;

    // Configuration values seen by the step logic
    typedef struct packed {
        logic [15:0] touch_threshold;
        logic [11:0] main_dwell_ticks;
        logic [11:0] warning_dwell_ticks;
    } cfg_t;

    // Sequencer state carried from one evaluation to the next
    typedef struct packed {
        phase_t      phase;
        logic [11:0] tick_count;
        logic [3:0]  fade_step;
        logic [2:0]  blinks_done;
        logic        touch_seen;
        logic        button_pending;
        logic [15:0] saved_red;
        logic [15:0] saved_green;
        logic [15:0] red_level;
        logic [15:0] green_level;
        logic [15:0] blue_level;
    } state_t;

endpackage

// File: rtl/tlfs_step.sv
// Next-state logic for one evaluation of the sequencer.
module tlfs_step #(
    parameter int FADE_STEPS = 15,
    parameter int DUTY_FULL  = 48000
) (
    input  tlfs_pkg::state_t cur,
    input  tlfs_pkg::cfg_t   cfg,
    input  logic             tick,
    input  logic [15:0]      touch_sample,
    input  logic             button_event,
    output tlfs_pkg::state_t nxt
);

    localparam logic signed [17:0] FULL_S     = 18'(DUTY_FULL);
    localparam logic signed [17:0] STEP_S     = 18'(DUTY_FULL >>> 4);
    localparam logic signed [17:0] XG_STEP_S  = 18'((DUTY_FULL - 3000) >>> 4);
    localparam logic signed [17:0] XB_STEP_S  = 18'(9000 >>> 4);
    localparam logic [3:0]         FADE_LAST  = 4'(FADE_STEPS);

    // Clamp a widened signed duty into 0..DUTY_FULL
    function automatic logic [15:0] clampd(input logic signed [17:0] v);
        logic [15:0] r;
        if (v < 18'sd0)
        begin
            r = 16'd0;
        end
        else if (v > FULL_S)
        begin
            r = 16'(FULL_S);
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // A sixteenth of the distance left from a saved level to full
    function automatic logic signed [17:0] remain16(input logic [15:0] saved);
        logic signed [17:0] d;
        d = FULL_S - $signed({2'b00, saved});
        if (d < 18'sd0)
        begin
            d = 18'sd0;
        end
        return d >>> 4;
    endfunction

    logic               pending;
    logic [11:0]        timer;
    logic               press;
    logic [3:0]         fs_inc;
    logic               fade_done;
    logic               ticked;
    logic signed [17:0] red_s;
    logic signed [17:0] green_s;
    logic signed [17:0] blue_s;

    // Inputs applied before the phase logic
    always_comb
    begin
        pending   = cur.button_pending | button_event;
        timer     = cur.tick_count;
        if (tick && (cur.tick_count != tlfs_pkg::TIMER_MAX))
        begin
            timer = cur.tick_count + 12'd1;
        end
        press     = (touch_sample > cfg.touch_threshold) || pending;
        ticked    = (timer != 12'd0);
        fs_inc    = cur.fade_step + 4'd1;
        fade_done = (fs_inc >= FADE_LAST);
        red_s     = $signed({2'b00, cur.red_level});
        green_s   = $signed({2'b00, cur.green_level});
        blue_s    = $signed({2'b00, cur.blue_level});
    end

    // Phase logic
    always_comb
    begin
        nxt                = cur;
        nxt.button_pending = pending;
        nxt.tick_count     = timer;
        case (cur.phase)
            tlfs_pkg::PH_STOP:
            begin
                if (press)
                begin
                    nxt.phase          = tlfs_pkg::PH_STOP_WARN;
                    nxt.touch_seen     = 1'b1;
                    nxt.button_pending = 1'b0;
                end
                else if (timer >= cfg.main_dwell_ticks)
                begin
                    nxt.tick_count = 12'd0;
                    nxt.phase      = tlfs_pkg::PH_STOP_GO;
                    nxt.touch_seen = 1'b0;
                end
            end
            tlfs_pkg::PH_GO:
            begin
                if (press)
                begin
                    nxt.phase          = tlfs_pkg::PH_GO_WARN;
                    nxt.touch_seen     = 1'b1;
                    nxt.button_pending = 1'b0;
                end
                else if (timer >= cfg.main_dwell_ticks)
                begin
                    nxt.tick_count = 12'd0;
                    nxt.phase      = tlfs_pkg::PH_GO_WARN;
                    nxt.touch_seen = 1'b0;
                end
            end
            tlfs_pkg::PH_WARN:
            begin
                if (press)
                begin
                    nxt.touch_seen     = 1'b1;
                    nxt.button_pending = 1'b0;
                    nxt.tick_count     = 12'd0;
                end
                else if (timer >= cfg.warning_dwell_ticks)
                begin
                    nxt.tick_count = 12'd0;
                    if (cur.touch_seen)
                    begin
                        nxt.phase      = tlfs_pkg::PH_WARN_XWALK;
                        nxt.touch_seen = 1'b0;
                    end
                    else
                    begin
                        nxt.phase = tlfs_pkg::PH_WARN_STOP;
                    end
                end
            end
            tlfs_pkg::PH_XWALK:
            begin
                // Off, then the walk colour, then count one blink
                if (ticked && (timer <= tlfs_pkg::BLINK_OFF_END))
                begin
                    nxt.red_level   = 16'd0;
                    nxt.green_level = 16'd0;
                    nxt.blue_level  = 16'd0;
                end
                else if (ticked && (timer <= tlfs_pkg::BLINK_ON_END))
                begin
                    nxt.red_level   = 16'd0;
                    nxt.green_level = tlfs_pkg::XWALK_GREEN;
                    nxt.blue_level  = tlfs_pkg::XWALK_BLUE;
                end
                else if (ticked)
                begin
                    nxt.tick_count  = 12'd0;
                    nxt.blinks_done = cur.blinks_done + 3'd1;
                    if ((cur.blinks_done + 3'd1) >= tlfs_pkg::BLINK_TOTAL)
                    begin
                        nxt.phase       = tlfs_pkg::PH_XWALK_GO;
                        nxt.blinks_done = 3'd0;
                    end
                end
            end
            tlfs_pkg::PH_STOP_GO:
            begin
                if (ticked)
                begin
                    if (press)
                    begin
                        nxt.phase          = tlfs_pkg::PH_STOP_GO_T;
                        nxt.touch_seen     = 1'b1;
                        nxt.button_pending = 1'b0;
                        nxt.saved_red      = cur.red_level;
                        nxt.saved_green    = cur.green_level;
                        nxt.fade_step      = 4'd0;
                        nxt.tick_count     = 12'd0;
                    end
                    else
                    begin
                        nxt.red_level   = clampd(red_s - STEP_S);
                        nxt.green_level = clampd(green_s + STEP_S);
                        nxt.blue_level  = 16'd0;
                        nxt.tick_count  = 12'd0;
                        nxt.fade_step   = fade_done ? 4'd0 : fs_inc;
                        nxt.phase       = fade_done ? tlfs_pkg::PH_GO : cur.phase;
                    end
                end
            end
            tlfs_pkg::PH_STOP_GO_T:
            begin
                if (ticked)
                begin
                    nxt.red_level   = clampd(red_s + remain16(cur.saved_red));
                    nxt.green_level = clampd(green_s + remain16(cur.saved_green));
                    nxt.blue_level  = 16'd0;
                    nxt.tick_count  = 12'd0;
                    nxt.fade_step   = fade_done ? 4'd0 : fs_inc;
                    nxt.phase       = fade_done ? tlfs_pkg::PH_WARN : cur.phase;
                end
            end
            tlfs_pkg::PH_STOP_WARN:
            begin
                if (ticked)
                begin
                    nxt.green_level = clampd(green_s + STEP_S);
                    nxt.blue_level  = 16'd0;
                    nxt.tick_count  = 12'd0;
                    nxt.fade_step   = fade_done ? 4'd0 : fs_inc;
                    nxt.phase       = fade_done ? tlfs_pkg::PH_WARN : cur.phase;
                end
            end
            tlfs_pkg::PH_GO_WARN:
            begin
                if (ticked)
                begin
                    if (press)
                    begin
                        nxt.touch_seen     = 1'b1;
                        nxt.button_pending = 1'b0;
                    end
                    nxt.red_level  = clampd(red_s + STEP_S);
                    nxt.blue_level = 16'd0;
                    nxt.tick_count = 12'd0;
                    nxt.fade_step  = fade_done ? 4'd0 : fs_inc;
                    nxt.phase      = fade_done ? tlfs_pkg::PH_WARN : cur.phase;
                end
            end
            tlfs_pkg::PH_WARN_STOP:
            begin
                if (ticked)
                begin
                    if (press)
                    begin
                        nxt.phase          = tlfs_pkg::PH_WARN_STOP_T;
                        nxt.touch_seen     = 1'b1;
                        nxt.button_pending = 1'b0;
                        nxt.saved_green    = cur.green_level;
                        nxt.fade_step      = 4'd0;
                        nxt.tick_count     = 12'd0;
                    end
                    else
                    begin
                        nxt.red_level   = 16'(FULL_S);
                        nxt.green_level = clampd(green_s - STEP_S);
                        nxt.blue_level  = 16'd0;
                        nxt.tick_count  = 12'd0;
                        nxt.fade_step   = fade_done ? 4'd0 : fs_inc;
                        nxt.phase       = fade_done ? tlfs_pkg::PH_STOP : cur.phase;
                    end
                end
            end
            tlfs_pkg::PH_WARN_STOP_T:
            begin
                if (ticked)
                begin
                    nxt.green_level = clampd(green_s + remain16(cur.saved_green));
                    nxt.blue_level  = 16'd0;
                    nxt.tick_count  = 12'd0;
                    nxt.fade_step   = fade_done ? 4'd0 : fs_inc;
                    nxt.phase       = fade_done ? tlfs_pkg::PH_WARN : cur.phase;
                end
            end
            tlfs_pkg::PH_XWALK_GO:
            begin
                if (ticked)
                begin
                    nxt.green_level = clampd(green_s + XG_STEP_S);
                    nxt.blue_level  = clampd(blue_s - XB_STEP_S);
                    nxt.red_level   = 16'd0;
                    nxt.tick_count  = 12'd0;
                    nxt.fade_step   = fade_done ? 4'd0 : fs_inc;
                    nxt.phase       = fade_done ? tlfs_pkg::PH_GO : cur.phase;
                    if (fade_done)
                    begin
                        nxt.button_pending = 1'b0;
                    end
                end
            end
            tlfs_pkg::PH_WARN_XWALK:
            begin
                if (ticked)
                begin
                    nxt.red_level   = clampd(red_s - STEP_S);
                    nxt.green_level = clampd(green_s - STEP_S);
                    nxt.blue_level  = 16'd0;
                    nxt.tick_count  = 12'd0;
                    nxt.fade_step   = fade_done ? 4'd0 : fs_inc;
                    nxt.phase       = fade_done ? tlfs_pkg::PH_XWALK : cur.phase;
                end
            end
            default:
            begin
                // Unused phase codes take only the tick and button updates.
            end
        endcase
    end

endmodule

// File: rtl/traffic_light_fade_sequencer.sv
// Traffic-light fade sequencer. Each input beat is one evaluation carrying a
// tick flag, a touch sample and a button flag; each one produces exactly one
// output beat with the red, green and blue PWM compare values and the phase
// code. A beat is registered on entry, evaluated by the combinational step
// logic while it sits in the input register and written to the output
// register, so the block accepts a beat every cycle while the output side
// keeps up. The configuration port may be written only while no evaluation
// is in flight; an index of three is ignored.
module traffic_light_fade_sequencer #(
    parameter int FADE_STEPS = 15,
    parameter int DUTY_FULL  = 48000
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] tick, [16:1] touch_sample, [17] button_event, [23:18] zero
    input  logic [23:0] s_tdata,
    // Output beats
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] red_duty, [31:16] green_duty, [47:32] blue_duty, [51:48] phase,
    // [55:52] zero
    output logic [55:0] m_tdata,
    // Configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    tlfs_pkg::cfg_t   cfg_reg;
    tlfs_pkg::state_t state_reg;
    tlfs_pkg::state_t state_next;

    logic        in_valid_reg;
    logic        in_tick_reg;
    logic [15:0] in_touch_reg;
    logic        in_button_reg;
    logic        out_valid_reg;
    logic [51:0] out_data_reg;
    logic        advance;

    // The input stage moves on when the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.touch_threshold     <= tlfs_pkg::TOUCH_THRESHOLD_RST;
            cfg_reg.main_dwell_ticks    <= tlfs_pkg::MAIN_DWELL_RST;
            cfg_reg.warning_dwell_ticks <= tlfs_pkg::WARN_DWELL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                tlfs_pkg::REG_TOUCH_THRESHOLD: cfg_reg.touch_threshold <= cfg_wdata;
                tlfs_pkg::REG_MAIN_DWELL:      cfg_reg.main_dwell_ticks <= cfg_wdata[11:0];
                tlfs_pkg::REG_WARN_DWELL:      cfg_reg.warning_dwell_ticks <= cfg_wdata[11:0];
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_tick_reg   <= s_tdata[0];
            in_touch_reg  <= s_tdata[16:1];
            in_button_reg <= s_tdata[17];
        end
    end

    // One evaluation of the sequencer
    tlfs_step #(
        .FADE_STEPS (FADE_STEPS),
        .DUTY_FULL  (DUTY_FULL)
    ) u_step (
        .cur          (state_reg),
        .cfg          (cfg_reg),
        .tick         (in_tick_reg),
        .touch_sample (in_touch_reg),
        .button_event (in_button_reg),
        .nxt          (state_next)
    );

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= tlfs_pkg::PH_STOP;
            state_reg.tick_count     <= 12'd0;
            state_reg.fade_step      <= 4'd0;
            state_reg.blinks_done    <= 3'd0;
            state_reg.touch_seen     <= 1'b0;
            state_reg.button_pending <= 1'b0;
            state_reg.saved_red      <= 16'd0;
            state_reg.saved_green    <= 16'd0;
            state_reg.red_level      <= 16'(DUTY_FULL);
            state_reg.green_level    <= 16'd0;
            state_reg.blue_level     <= 16'd0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {state_next.phase, state_next.blue_level,
                             state_next.green_level, state_next.red_level};
        end
    end

endmodule

// File: rtl/tlfs_checker.sv
// Port-level checks for the traffic-light fade sequencer.
module tlfs_checker #(
    parameter int DUTY_FULL = 48000
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // The phase code on an output beat is always a real phase
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[51:48] <= 4'd11))
        else $error("phase code out of range");

    // Every duty stays inside the clamp range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[15:0] <= 16'(DUTY_FULL))
                   && (m_tdata[31:16] <= 16'(DUTY_FULL))
                   && (m_tdata[47:32] <= 16'(DUTY_FULL))))
        else $error("duty above full scale");

    // The input side only stalls when both stages are full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // A held output beat keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output beat changed while stalled");

endmodule

bind traffic_light_fade_sequencer tlfs_checker #(
    .DUTY_FULL (DUTY_FULL)
) u_tlfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
